### rtl/ttd_pkg.sv
// Shared types and constants for the tune event to tone decoder.
// Used by ttd_div and tune_event_to_tone_decoder; no dependencies.

package ttd_pkg;

  localparam int DVD_W = 26;
  localparam int DVS_W = 17;
  localparam int CNT_W = $clog2(DVD_W);

  localparam logic [7:0]       EXT_MARK  = 8'd255;
  localparam logic [7:0]       CNT_MAX   = 8'd255;
  localparam logic [15:0]      EXT_UNITS = 16'd254;
  localparam logic [3:0]       VOL_MAX   = 4'd11;
  localparam logic [3:0]       VOL_RESET = 4'd5;

  localparam logic [DVD_W-1:0] HZ_NUM    = DVD_W'(10000000);
  localparam logic [DVD_W-1:0] RLD_NUM   = DVD_W'(4800000);
  localparam logic [DVS_W-1:0] CODE_MUL  = DVS_W'(247);
  localparam logic [DVS_W-1:0] CODE_OFS  = DVS_W'(4000);
  localparam logic [DVD_W-1:0] MS_MUL    = DVD_W'(1000);

  localparam logic [9:0]       CMP_SAT   = 10'h3ff;
  localparam logic [15:0]      DUR_SAT   = 16'hffff;

  localparam logic [2:0]       ADDR_VOL  = 3'd0;

endpackage

### rtl/tune_event_to_tone_decoder.sv
// Top level: event decode, sequencer over the shared divider, APB register.
// Depends on ttd_pkg and ttd_div.
//
//   channel   dir   handshake                 payload
//   s_axis    in    s_tvalid / s_tready       s_tdata: time_byte, note_code
//   m_axis    out   m_tvalid / m_tready       m_tdata: tone fields; m_tuser: is_rest
//   apb       in    psel/penable/pwrite       volume_level: read at address 0, written at 0-3
//
// An extension event is taken in the idle state alone; a rest goes straight to
// the output state and waits there for the output register. A tone runs four
// serial 26-bit divisions on the one shared divider, each with a start and a
// wait-for-done state, then the output state loads the output register.
// s_tready is high only while the sequencer is idle; a result holds in the
// output register until m_tready while the next item is taken in.
// Reset clears the count, the volume to 5.

module tune_event_to_tone_decoder #(
  parameter int FULL_RELOAD = 1999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] time_byte, [15:8] note_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [11:0] tone_hz, [26:12] period_reload,
                                 // [36:27] duty_compare, [52:37] duration_ms
  output logic        m_tuser,   // [0] is_rest
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ttd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HZ, S_HZ_W, S_RLD, S_RLD_W, S_CMP, S_CMP_W, S_DUR, S_DUR_W, S_OUT
  } state_t;

  state_t           state;
  logic [3:0]       volume_level;
  logic [7:0]       extension_count;
  logic [7:0]       code;
  logic [15:0]      units;
  logic [15:0]      units_next;
  logic             is_rest;
  logic [11:0]      tone_hz;
  logic [14:0]      period_reload;
  logic [9:0]       duty_compare;
  logic [15:0]      duration_ms;
  logic [3:0]       vol;
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DVD_W-1:0] div_quo;
  logic             in_acc;
  logic             out_load;
  logic [7:0]       time_byte;
  logic [7:0]       note_code;

  assign time_byte  = s_tdata[7:0];
  assign note_code  = s_tdata[15:8];
  assign s_tready   = (state == S_IDLE);
  assign in_acc     = s_tvalid && s_tready;
  assign out_load   = (state == S_OUT) && (!m_tvalid || m_tready);
  assign units_next = 16'(extension_count) * EXT_UNITS + 16'(time_byte);
  assign vol        = (volume_level > VOL_MAX) ? VOL_MAX : volume_level;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VOL) ? {28'd0, volume_level} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_level <= VOL_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      volume_level <= pwdata[3:0];
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state)
      S_HZ: begin
        div_start = 1'b1;
        div_dvd   = HZ_NUM;
        div_dvs   = DVS_W'(code) * CODE_MUL + CODE_OFS;
      end
      S_RLD: begin
        div_start = 1'b1;
        div_dvd   = RLD_NUM;
        div_dvs   = DVS_W'(tone_hz);
      end
      S_CMP: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({DVD_W'(vol) * DVD_W'(period_reload), 1'b0});
        div_dvs   = DVS_W'(FULL_RELOAD);
      end
      S_DUR: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(units) * MS_MUL;
        div_dvs   = DVS_W'(tone_hz);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ttd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      extension_count <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (time_byte == EXT_MARK) begin
              if (extension_count != CNT_MAX) begin
                extension_count <= extension_count + 1'b1;
              end
            end else begin
              extension_count <= '0;
              units           <= units_next;
              code            <= note_code;
              if (note_code == 8'd0) begin
                is_rest       <= 1'b1;
                tone_hz       <= '0;
                period_reload <= '0;
                duty_compare  <= '0;
                duration_ms   <= units_next;
                state         <= S_OUT;
              end else begin
                is_rest <= 1'b0;
                state   <= S_HZ;
              end
            end
          end
        end
        S_HZ:  state <= S_HZ_W;
        S_HZ_W: begin
          if (div_done) begin
            tone_hz <= div_quo[11:0];
            state   <= S_RLD;
          end
        end
        S_RLD: state <= S_RLD_W;
        S_RLD_W: begin
          if (div_done) begin
            period_reload <= div_quo[14:0];
            state         <= S_CMP;
          end
        end
        S_CMP: state <= S_CMP_W;
        S_CMP_W: begin
          if (div_done) begin
            duty_compare <= (|div_quo[DVD_W-1:10]) ? CMP_SAT : div_quo[9:0];
            state        <= S_DUR;
          end
        end
        S_DUR: state <= S_DUR_W;
        S_DUR_W: begin
          if (div_done) begin
            duration_ms <= (|div_quo[DVD_W-1:16]) ? DUR_SAT : div_quo[15:0];
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_tdata <= {3'd0, duration_ms, duty_compare, period_reload, tone_hz};
            m_tuser <= is_rest;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/ttd_div.sv
// Shared restoring divider: one quotient bit per cycle, DVD_W quotient bits in all.
// Depends on ttd_pkg for operand widths.

module ttd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ttd_pkg::DVD_W-1:0]  dividend,
  input  logic [ttd_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [ttd_pkg::DVD_W-1:0]  quotient
);
  import ttd_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        quo <= {quo[DVD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### sim/tune_event_to_tone_decoder_tb.sv
// Self-checking bench for tune_event_to_tone_decoder: a stimulus table, then random
// phases at several volume settings; results are checked against table values or an in-bench predictor.
// Depends on ttd_pkg and the decoder RTL.

module tune_event_to_tone_decoder_tb;
  import ttd_pkg::*;

  localparam int FULL_RELOAD   = 1999;
  localparam int TONE_CLOCK    = 10000000;
  localparam int CODE_STEP     = 247;
  localparam int CODE_BASE     = 4000;
  localparam int TIMER_CLOCK   = 4800000;
  localparam int UNITS_PER_EXT = 254;
  localparam int MS_PER_S      = 1000;
  localparam int LOUDEST       = 11;
  localparam int DUTY_CEIL     = 1023;
  localparam int DUR_CEIL      = 65535;
  localparam int SETTLE        = 150;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 160;

  typedef struct packed {
    logic        is_rest;
    logic [11:0] hz;
    logic [14:0] reload;
    logic [9:0]  duty;
    logic [15:0] dur_ms;
  } tone_result_t;

  typedef enum {STEP_EVENT, STEP_VOLUME} step_kind_t;

  typedef struct {
    step_kind_t   kind;
    logic [7:0]   t;
    logic [7:0]   code;
    int           reps;
    bit           typed;
    tone_result_t want;
  } script_step_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] time_byte, [15:8] note_code
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // [11:0] tone_hz, [26:12] period_reload,
                          // [36:27] duty_compare, [52:37] duration_ms
  logic        m_tuser;   // [0] is_rest
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tone_result_t tone_q[$];
  script_step_t script[$];
  logic [7:0]   ext_count;
  logic [3:0]   volume_setting;
  int           failures = 0;
  int           quiet_cycles = 0;
  bit           send_gaps = 1'b0;
  bit           recv_gaps = 1'b0;
  int           recv_hold = 0;

  tune_event_to_tone_decoder #(.FULL_RELOAD(FULL_RELOAD)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit decode_event(input logic [7:0] t, input logic [7:0] code,
                                      output tone_result_t r);
    longint units;
    longint hz;
    longint reload;
    longint duty;
    longint dur;
    longint vol;
    r = '0;
    if (t == EXT_MARK) begin
      if (ext_count != 8'hff) ext_count = ext_count + 8'd1;
      return 1'b0;
    end
    units = longint'(ext_count) * UNITS_PER_EXT + longint'(t);
    ext_count = '0;
    if (code == 8'd0) begin
      r.is_rest = 1'b1;
      r.dur_ms  = units[15:0];
      return 1'b1;
    end
    hz     = TONE_CLOCK / (longint'(code) * CODE_STEP + CODE_BASE);
    reload = TIMER_CLOCK / hz;
    vol    = (volume_setting > LOUDEST) ? LOUDEST : longint'(volume_setting);
    duty   = (2 * vol * reload) / FULL_RELOAD;
    if (duty > DUTY_CEIL) duty = DUTY_CEIL;
    dur    = (units * MS_PER_S) / hz;
    if (dur > DUR_CEIL) dur = DUR_CEIL;
    r.hz     = hz[11:0];
    r.reload = reload[14:0];
    r.duty   = duty[9:0];
    r.dur_ms = dur[15:0];
    return 1'b1;
  endfunction

  function automatic void add_step(input step_kind_t kind, input logic [7:0] t,
                                   input logic [7:0] code, input int reps, input bit typed,
                                   input tone_result_t want);
    script_step_t s;
    s.kind  = kind;
    s.t     = t;
    s.code  = code;
    s.reps  = reps;
    s.typed = typed;
    s.want  = want;
    script.push_back(s);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic push_event(input logic [7:0] t, input logic [7:0] code, input bit typed,
                            input tone_result_t want);
    tone_result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= {code, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (decode_event(t, code, r)) tone_q.push_back(typed ? want : r);
  endtask

  task automatic sender_pause(input int n);
    s_tvalid <= 1'b0;
    s_tdata  <= 16'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_volume(input logic [3:0] level);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_VOL;
    pwdata  <= {28'($urandom), level};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    volume_setting = level;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("volume_level readback", int'(level), int'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receive side: random back-pressure and result checking
  always @(posedge clk) begin
    tone_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (tone_q.size() == 0) begin
          $error("result with no event pending: tdata %h tuser %b", m_tdata, m_tuser);
          failures++;
        end else begin
          want = tone_q.pop_front();
          check_field("is_rest", int'(want.is_rest), int'(m_tuser));
          check_field("tone_hz", int'(want.hz), int'(m_tdata[11:0]));
          check_field("period_reload", int'(want.reload), int'(m_tdata[26:12]));
          check_field("duty_compare", int'(want.duty), int'(m_tdata[36:27]));
          check_field("duration_ms", int'(want.dur_ms), int'(m_tdata[52:37]));
        end
      end
      if (recv_hold > 0) begin
        recv_hold = recv_hold - 1;
        m_tready <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
        recv_hold = $urandom_range(1, 5) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    tone_result_t want;
    tone_result_t none;
    script_step_t s;
    logic [3:0]   levels [PHASES];
    logic [3:0]   level;
    int           sent;
    int           n;
    int           pick;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    ext_count      = '0;
    volume_setting = VOL_RESET;
    none           = '0;
    levels = '{4'd0, 4'd15, 4'd11, 4'd12, 4'd3, 4'd0, 4'd1};

    // rests with an exact length, the tone extremes, the full extension count and volume changes
    want = '0; want.is_rest = 1'b1;
    add_step(STEP_EVENT, 8'd0, 8'd0, 1, 1'b1, want);
    want.dur_ms = 16'd254;
    add_step(STEP_EVENT, 8'd254, 8'd0, 1, 1'b1, want);
    add_step(STEP_EVENT, 8'd1, 8'd1, 1, 1'b0, none);
    add_step(STEP_EVENT, 8'd254, 8'd255, 1, 1'b0, none);
    add_step(STEP_EVENT, 8'd255, 8'd0, 1, 1'b0, none);
    add_step(STEP_EVENT, 8'd255, 8'd255, 1, 1'b0, none);
    want.dur_ms = 16'd508;
    add_step(STEP_EVENT, 8'd0, 8'd0, 1, 1'b1, want);
    add_step(STEP_EVENT, 8'd255, 8'd1, 300, 1'b0, none);
    want.dur_ms = 16'd65024;
    add_step(STEP_EVENT, 8'd254, 8'd0, 1, 1'b1, want);
    add_step(STEP_EVENT, 8'd255, 8'd128, 260, 1'b0, none);
    want = '{1'b0, 12'd149, 15'd32214, 10'd161, 16'hffff};
    add_step(STEP_EVENT, 8'd254, 8'd255, 1, 1'b1, want);
    add_step(STEP_EVENT, 8'd254, 8'd1, 1, 1'b0, none);
    want = '{1'b0, 12'd2354, 15'd2039, 10'd10, 16'd0};
    add_step(STEP_EVENT, 8'd0, 8'd1, 1, 1'b1, want);
    add_step(STEP_EVENT, 8'd255, 8'd7, 3, 1'b0, none);
    add_step(STEP_EVENT, 8'd200, 8'd64, 1, 1'b0, none);
    add_step(STEP_VOLUME, 8'd15, 8'd0, 1, 1'b0, none);
    want = '{1'b0, 12'd149, 15'd32214, 10'd354, 16'd0};
    add_step(STEP_EVENT, 8'd0, 8'd255, 1, 1'b1, want);
    add_step(STEP_VOLUME, 8'd12, 8'd0, 1, 1'b0, none);
    add_step(STEP_EVENT, 8'd100, 8'd170, 1, 1'b0, none);
    add_step(STEP_VOLUME, 8'd0, 8'd0, 1, 1'b0, none);
    want = '{1'b0, 12'd149, 15'd32214, 10'd0, 16'd67};
    add_step(STEP_EVENT, 8'd10, 8'd255, 1, 1'b1, want);
    add_step(STEP_EVENT, 8'haa, 8'h55, 1, 1'b0, none);
    add_step(STEP_EVENT, 8'h55, 8'haa, 1, 1'b0, none);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      s = script[i];
      if (s.kind == STEP_VOLUME) begin
        set_volume(s.t[3:0]);
      end else begin
        repeat (s.reps) push_event(s.t, s.code, s.typed, s.want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      level = (ph == 5) ? 4'($urandom_range(0, 15)) : levels[ph];
      set_volume(level);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent % 60 == 0) begin
          send_gaps = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
          recv_gaps = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          n = ($urandom_range(0, 99) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 4);
          repeat (n) push_event(EXT_MARK, 8'($urandom), 1'b0, none);
          sent += n;
        end else if (pick < 35) begin
          push_event(8'($urandom_range(0, 254)), 8'd0, 1'b0, none);
          sent++;
        end else if (pick < 90) begin
          push_event(8'($urandom_range(0, 254)), 8'($urandom_range(1, 255)), 1'b0, none);
          sent++;
        end else begin
          push_event(8'($urandom), 8'($urandom), 1'b0, none);
          sent++;
        end
        if (send_gaps && $urandom_range(0, 3) == 0) sender_pause($urandom_range(1, 5));
      end
    end

    s_tvalid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
